// ----- design/omfh_pkg.sv -----
package omfh_pkg;

	// wait queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int PID_W = 16;

	// apb
	localparam int APB_AW = 2;
	localparam int APB_DW = 32;

	// apb register map
	localparam logic [APB_AW-1:0] ADDR_KERNEL_READY = APB_AW'(0);

	// requested operation
	localparam logic FUNC_LOCK = 1'b0;
	localparam logic FUNC_UNLOCK = 1'b1;

	// caller entry in the process table
	localparam logic [1:0] CS_NOT_FOUND = 2'd0;
	localparam logic [1:0] CS_RUNNABLE = 2'd1;
	localparam logic [1:0] CS_BLOCKED = 2'd2;
	localparam logic [1:0] CS_EXITED = 2'd3;

	// head waiter entry in the process table
	localparam logic [1:0] HS_NOT_FOUND = 2'd0;
	localparam logic [1:0] HS_BLOCKED = 2'd1;
	localparam logic [1:0] HS_OTHER = 2'd2;

	// response status codes
	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BLOCKED = 3'd1;
	localparam logic [2:0] ST_STATE = 3'd2;
	localparam logic [2:0] ST_RANGE = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;

	localparam logic signed [PID_W-1:0] PID_NONE = -16'sd1;

	typedef struct packed {
		logic func;
		logic signed [PID_W-1:0] requester_pid;
		logic [1:0] caller_state;
		logic [1:0] head_waiter_state;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic signed [PID_W-1:0] current_owner;
		logic lock_held;
		logic woke;
		logic signed [PID_W-1:0] woken_pid;
		logic signed [PID_W-1:0] head_waiter_pid;
		logic [CNT_W-1:0] waiter_count;
	} rsp_t;

endpackage

// ----- design/owned_mutex_fifo_handoff.sv -----
// owned mutex with a fifo wait queue of process ids
// a taken request passes the input register and then the result register before done rises
// throughput: one request per cycle, busy stays low; the receiver cannot stall
// the queue is a shift line, so the head waiter always sits in entry zero
// reset (arst_n low, asynchronous): mutex free, owner -1, queue empty,
// kernel_ready 0; queue entries are not cleared and are only read once pushed
module owned_mutex_fifo_handoff (
	input logic clk,
	input logic arst_n,
	// request channel
	input logic start,
	output logic busy,
	input omfh_pkg::req_t req,
	// result channel
	output logic done,
	output omfh_pkg::rsp_t rsp,
	// apb configuration port
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [omfh_pkg::APB_AW-1:0] paddr,
	input logic [omfh_pkg::APB_DW-1:0] pwdata,
	output logic [omfh_pkg::APB_DW-1:0] prdata,
	output logic pready
);

	// configuration register
	logic kernel_ready_q;

	// input register
	logic valid_s1;
	omfh_pkg::req_t req_s1;

	// mutex state
	logic locked_q;
	logic signed [omfh_pkg::PID_W-1:0] owner_q;
	logic [omfh_pkg::CNT_W-1:0] count_q;
	logic signed [omfh_pkg::PID_W-1:0] ring_q [omfh_pkg::QUEUE_DEPTH];

	// result register
	logic done_q;
	omfh_pkg::rsp_t rsp_q;

	// next-state logic
	logic [2:0] status;
	logic locked_nxt;
	logic signed [omfh_pkg::PID_W-1:0] owner_nxt;
	logic [omfh_pkg::CNT_W-1:0] count_nxt;
	logic push;
	logic pop;
	logic woke;
	logic pid_pos;
	logic signed [omfh_pkg::PID_W-1:0] head_nxt;

	// every request is taken at once
	assign busy = 1'b0;
	assign pready = 1'b1;
	assign prdata = {{(omfh_pkg::APB_DW-1){1'b0}}, kernel_ready_q};

	// single register at address zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_ready_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
				(paddr == omfh_pkg::ADDR_KERNEL_READY)) begin
			kernel_ready_q <= pwdata[0];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= req;
		end
	end

	assign pid_pos = !req_s1.requester_pid[omfh_pkg::PID_W-1] && (req_s1.requester_pid != '0);

	// decision for the registered request against the current mutex state
	always_comb begin
		status = omfh_pkg::ST_OK;
		locked_nxt = locked_q;
		owner_nxt = owner_q;
		count_nxt = count_q;
		push = 1'b0;
		pop = 1'b0;
		woke = 1'b0;
		if (!kernel_ready_q) begin
			status = omfh_pkg::ST_STATE;
		end else if (!pid_pos) begin
			status = omfh_pkg::ST_RANGE;
		end else if (req_s1.func == omfh_pkg::FUNC_LOCK) begin
			if (req_s1.caller_state == omfh_pkg::CS_NOT_FOUND) begin
				status = omfh_pkg::ST_NOT_FOUND;
			end else if (req_s1.caller_state == omfh_pkg::CS_BLOCKED ||
					req_s1.caller_state == omfh_pkg::CS_EXITED) begin
				status = omfh_pkg::ST_STATE;
			end else if (!locked_q) begin
				// free mutex: caller takes it
				locked_nxt = 1'b1;
				owner_nxt = req_s1.requester_pid;
			end else if (owner_q == req_s1.requester_pid) begin
				status = omfh_pkg::ST_STATE;
			end else if (count_q >= omfh_pkg::CNT_W'(omfh_pkg::QUEUE_DEPTH)) begin
				status = omfh_pkg::ST_FULL;
			end else begin
				// held by another process: caller waits
				status = omfh_pkg::ST_BLOCKED;
				push = 1'b1;
				count_nxt = count_q + omfh_pkg::CNT_W'(1);
			end
		end else begin
			if (!locked_q || owner_q != req_s1.requester_pid) begin
				status = omfh_pkg::ST_STATE;
			end else if (count_q == '0) begin
				// nobody waiting: mutex goes free
				locked_nxt = 1'b0;
				owner_nxt = omfh_pkg::PID_NONE;
			end else begin
				// hand off to the head waiter; pop is kept even when it fails
				pop = 1'b1;
				count_nxt = count_q - omfh_pkg::CNT_W'(1);
				if (req_s1.head_waiter_state != omfh_pkg::HS_BLOCKED) begin
					status = omfh_pkg::ST_STATE;
				end else begin
					woke = 1'b1;
					owner_nxt = ring_q[0];
				end
			end
		end
		if (!valid_s1) begin
			locked_nxt = locked_q;
			owner_nxt = owner_q;
			count_nxt = count_q;
			push = 1'b0;
			pop = 1'b0;
			woke = 1'b0;
		end
	end

	// head of the queue after this request
	always_comb begin
		if (count_nxt == '0) begin
			head_nxt = omfh_pkg::PID_NONE;
		end else if (pop) begin
			head_nxt = ring_q[1];
		end else if (push && count_q == '0) begin
			head_nxt = req_s1.requester_pid;
		end else begin
			head_nxt = ring_q[0];
		end
	end

	// mutex state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			locked_q <= 1'b0;
			owner_q <= omfh_pkg::PID_NONE;
			count_q <= '0;
		end else begin
			locked_q <= locked_nxt;
			owner_q <= owner_nxt;
			count_q <= count_nxt;
		end
	end

	// wait queue shift line: push writes at the tail, pop shifts toward entry zero
	always_ff @(posedge clk) begin
		for (int i = 0; i < omfh_pkg::QUEUE_DEPTH; i++) begin
			if (pop && i < omfh_pkg::QUEUE_DEPTH - 1) begin
				ring_q[i] <= ring_q[i+1];
			end else if (push && count_q[omfh_pkg::IDX_W-1:0] == omfh_pkg::IDX_W'(i)) begin
				ring_q[i] <= req_s1.requester_pid;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q.status <= status;
			rsp_q.current_owner <= locked_nxt ? owner_nxt : omfh_pkg::PID_NONE;
			rsp_q.lock_held <= locked_nxt;
			rsp_q.woke <= woke;
			rsp_q.woken_pid <= woke ? ring_q[0] : omfh_pkg::PID_NONE;
			rsp_q.head_waiter_pid <= head_nxt;
			rsp_q.waiter_count <= count_nxt;
		end
	end

	assign done = done_q;
	assign rsp = rsp_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= omfh_pkg::CNT_W'(omfh_pkg::QUEUE_DEPTH))
		else $error("wait queue count beyond depth");

	a_waiters_need_owner: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> locked_q)
		else $error("waiters queued on a free mutex");

	a_free_no_owner: assert property (@(posedge clk) disable iff (!arst_n)
		!locked_q |-> (owner_q == omfh_pkg::PID_NONE))
		else $error("free mutex still has an owner");

	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("request not answered");

	a_woke_is_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.woke) |-> (rsp.status == omfh_pkg::ST_OK && rsp.lock_held &&
			rsp.current_owner == rsp.woken_pid))
		else $error("handoff result inconsistent");
`endif

endmodule

// ----- bench/owned_mutex_fifo_handoff_test.sv -----
`timescale 1ns / 100ps

module owned_mutex_fifo_handoff_test;

	localparam int ITEMS = 1900;
	localparam int CALM_TAIL = 200;
	localparam int CYCLE_LIMIT = 400000;
	// a request is answered once it has passed the input and result registers
	localparam int DRAIN_CYCLES = 8;

	// one planned request; with as_owner set, the driver swaps in the
	// owner's id at the moment it drives the request, so unlocks hit home
	typedef struct {
		omfh_pkg::req_t r;
		bit as_owner;
	} req_plan_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	omfh_pkg::req_t req = '0;
	logic done;
	omfh_pkg::rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [omfh_pkg::APB_AW-1:0] paddr = '0;
	logic [omfh_pkg::APB_DW-1:0] pwdata = '0;
	logic [omfh_pkg::APB_DW-1:0] prdata;
	logic pready;

	owned_mutex_fifo_handoff dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// mirror of the mutex: config, lock flag, owner and the wait line
	logic mtx_ready = 1'b0;
	logic mtx_held = 1'b0;
	logic signed [omfh_pkg::PID_W-1:0] mtx_owner = omfh_pkg::PID_NONE;
	logic signed [omfh_pkg::PID_W-1:0] waiters[$];

	req_plan_t planned_reqs[$];
	omfh_pkg::rsp_t expected_rsps[$];

	// stimulus shaping, set per segment by the sequencer
	bit idle_on = 1'b0;
	bit calm = 1'b0;
	int gap_left = 0;
	bit req_taken = 1'b0;
	req_plan_t next_plan;
	omfh_pkg::rsp_t want;

	int mismatches = 0;
	int cycles = 0;
	int n_requests = 0;
	int n_results = 0;
	int n_handoffs = 0;
	int status_hits[8];

	// lock / unlock semantics applied to the mirror; returns the snapshot
	function automatic omfh_pkg::rsp_t predict_mutex_rsp(omfh_pkg::req_t r);
		omfh_pkg::rsp_t o;
		logic [2:0] st;
		logic signed [omfh_pkg::PID_W-1:0] woken;
		logic signed [omfh_pkg::PID_W-1:0] popped;
		woken = omfh_pkg::PID_NONE;
		if (!mtx_ready) begin
			st = omfh_pkg::ST_STATE;
		end else if (r.func == omfh_pkg::FUNC_LOCK) begin
			if (r.requester_pid <= 0)
				st = omfh_pkg::ST_RANGE;
			else if (r.caller_state == omfh_pkg::CS_NOT_FOUND)
				st = omfh_pkg::ST_NOT_FOUND;
			else if (r.caller_state == omfh_pkg::CS_BLOCKED ||
					r.caller_state == omfh_pkg::CS_EXITED)
				st = omfh_pkg::ST_STATE;
			else if (!mtx_held) begin
				mtx_held = 1'b1;
				mtx_owner = r.requester_pid;
				st = omfh_pkg::ST_OK;
			end else if (mtx_owner == r.requester_pid)
				st = omfh_pkg::ST_STATE;
			else if (waiters.size() >= omfh_pkg::QUEUE_DEPTH)
				st = omfh_pkg::ST_FULL;
			else begin
				waiters.push_back(r.requester_pid);
				st = omfh_pkg::ST_BLOCKED;
			end
		end else begin
			if (r.requester_pid <= 0)
				st = omfh_pkg::ST_RANGE;
			else if (!mtx_held || mtx_owner != r.requester_pid)
				st = omfh_pkg::ST_STATE;
			else if (waiters.size() == 0) begin
				mtx_held = 1'b0;
				mtx_owner = omfh_pkg::PID_NONE;
				st = omfh_pkg::ST_OK;
			end else begin
				// the pop stands even when the waiter turns out not blocked
				popped = waiters.pop_front();
				if (r.head_waiter_state != omfh_pkg::HS_BLOCKED)
					st = omfh_pkg::ST_STATE;
				else begin
					mtx_owner = popped;
					woken = popped;
					st = omfh_pkg::ST_OK;
				end
			end
		end
		o.status = st;
		o.current_owner = mtx_held ? mtx_owner : omfh_pkg::PID_NONE;
		o.lock_held = mtx_held;
		o.woke = (woken != omfh_pkg::PID_NONE);
		o.woken_pid = woken;
		o.head_waiter_pid = (waiters.size() == 0) ? omfh_pkg::PID_NONE : waiters[0];
		o.waiter_count = omfh_pkg::CNT_W'(waiters.size());
		return o;
	endfunction

	function automatic void check_field(string name, logic signed [31:0] exp_v,
		logic signed [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			mismatches++;
		end
	endfunction

	function automatic void plan(logic func, logic signed [omfh_pkg::PID_W-1:0] pid,
		logic [1:0] cs, logic [1:0] hs, bit as_owner);
		req_plan_t p;
		p.r.func = func;
		p.r.requester_pid = pid;
		p.r.caller_state = cs;
		p.r.head_waiter_state = hs;
		p.as_owner = as_owner;
		planned_reqs.push_back(p);
	endfunction

	// mostly well-formed traffic over a small id pool so the same
	// processes keep meeting; lock_pct skews toward filling or draining
	function automatic void plan_random(int lock_pct);
		int roll;
		logic signed [omfh_pkg::PID_W-1:0] pid;
		logic [1:0] cs;
		logic [1:0] hs;
		roll = $urandom_range(0, 99);
		pid = ($urandom_range(0, 9) < 7) ? omfh_pkg::PID_W'($urandom_range(1, 24))
			: omfh_pkg::PID_W'($urandom_range(1, 32767));
		cs = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
			: omfh_pkg::CS_RUNNABLE;
		hs = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3))
			: omfh_pkg::HS_BLOCKED;
		if (roll < 10) begin
			// noise: anything the fields can carry
			plan(1'($urandom), omfh_pkg::PID_W'($urandom), 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)), 1'b0);
		end else if (roll < 10 + lock_pct) begin
			// now and then the owner asks again
			plan(omfh_pkg::FUNC_LOCK, pid, cs, hs, $urandom_range(0, 19) == 0);
		end else begin
			plan(omfh_pkg::FUNC_UNLOCK, pid, cs, hs, $urandom_range(0, 6) != 0);
		end
	endfunction

	task automatic apb_access(input logic wr, input logic [omfh_pkg::APB_DW-1:0] wdata,
		output logic [omfh_pkg::APB_DW-1:0] rdata);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= omfh_pkg::ADDR_KERNEL_READY;
		pwdata <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// only called with the mutex idle, so the mirror can flip at once
	task automatic set_kernel_ready(input logic v);
		logic [omfh_pkg::APB_DW-1:0] rd;
		apb_access(1'b1, omfh_pkg::APB_DW'(v), rd);
		mtx_ready = v;
		apb_access(1'b0, '0, rd);
		check_field("kernel_ready readback", omfh_pkg::APB_DW'(v), rd);
	endtask

	// wait until every planned request is taken and answered
	task automatic drain();
		do @(posedge clk);
		while (planned_reqs.size() != 0 || start || expected_rsps.size() != 0);
	endtask

	// driver: a request stays up until taken; idle bursts fall between
	always @(negedge clk) begin
		if (arst_n && !(start && !req_taken)) begin
			if (gap_left == 0 && idle_on && !calm && planned_reqs.size() != 0
				&& $urandom_range(0, 9) == 0)
				gap_left = $urandom_range(1, 11);
			if (gap_left != 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (planned_reqs.size() == 0) begin
				start <= 1'b0;
			end else begin
				next_plan = planned_reqs.pop_front();
				// the mirror is exact here: nothing else is in flight to change it
				if (next_plan.as_owner && mtx_held)
					next_plan.r.requester_pid = mtx_owner;
				req <= next_plan.r;
				start <= 1'b1;
			end
		end
	end

	// monitor: results are checked before this edge's request is predicted
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				n_results++;
				if (expected_rsps.size() == 0) begin
					$error("result with no request pending: status %0d", rsp.status);
					mismatches++;
				end else begin
					want = expected_rsps.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("current_owner", want.current_owner, rsp.current_owner);
					check_field("lock_held", want.lock_held, rsp.lock_held);
					check_field("woke", want.woke, rsp.woke);
					check_field("woken_pid", want.woken_pid, rsp.woken_pid);
					check_field("head_waiter_pid", want.head_waiter_pid,
						rsp.head_waiter_pid);
					check_field("waiter_count", want.waiter_count, rsp.waiter_count);
				end
			end
			req_taken = start && !busy;
			if (req_taken) begin
				want = predict_mutex_rsp(req);
				expected_rsps.push_back(want);
				n_requests++;
				status_hits[want.status]++;
				if (want.woke)
					n_handoffs++;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, expected_rsps.size());
			$display("** owned_mutex_fifo_handoff: FAILED **");
			$finish;
		end
	end

	initial begin
		int seg_len;
		int lock_pct;
		int n_planned;
		logic ready_sel;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// kernel not up: every request is a state error
		set_kernel_ready(1'b0);
		plan(omfh_pkg::FUNC_LOCK, 16'sd5, omfh_pkg::CS_RUNNABLE, omfh_pkg::HS_BLOCKED, 1'b0);
		plan(omfh_pkg::FUNC_UNLOCK, 16'sd5, omfh_pkg::CS_RUNNABLE, omfh_pkg::HS_BLOCKED, 1'b0);
		drain();

		set_kernel_ready(1'b1);
		// unlock of a free mutex
		plan(omfh_pkg::FUNC_UNLOCK, 16'sd1, omfh_pkg::CS_RUNNABLE, omfh_pkg::HS_BLOCKED, 1'b0);
		// largest id takes the lock, then asks again
		plan(omfh_pkg::FUNC_LOCK, 16'sh7fff, omfh_pkg::CS_RUNNABLE, omfh_pkg::HS_BLOCKED, 1'b0);
		plan(omfh_pkg::FUNC_LOCK, 16'sh7fff, omfh_pkg::CS_RUNNABLE, omfh_pkg::HS_BLOCKED, 1'b0);
		// ids not above zero
		plan(omfh_pkg::FUNC_LOCK, -16'sd32768, omfh_pkg::CS_RUNNABLE,
			omfh_pkg::HS_BLOCKED, 1'b0);
		plan(omfh_pkg::FUNC_LOCK, 16'sd0, omfh_pkg::CS_RUNNABLE, omfh_pkg::HS_BLOCKED, 1'b0);
		// caller unknown, blocked, exited
		plan(omfh_pkg::FUNC_LOCK, 16'sd5, omfh_pkg::CS_NOT_FOUND, omfh_pkg::HS_BLOCKED, 1'b0);
		plan(omfh_pkg::FUNC_LOCK, 16'sd6, omfh_pkg::CS_BLOCKED, omfh_pkg::HS_BLOCKED, 1'b0);
		plan(omfh_pkg::FUNC_LOCK, 16'sd7, omfh_pkg::CS_EXITED, omfh_pkg::HS_BLOCKED, 1'b0);
		// unlock by someone who is not the owner
		plan(omfh_pkg::FUNC_UNLOCK, 16'sd9, omfh_pkg::CS_RUNNABLE, omfh_pkg::HS_BLOCKED, 1'b0);
		// fill the wait line, then one more bounces off
		for (int k = 0; k < omfh_pkg::QUEUE_DEPTH; k++)
			plan(omfh_pkg::FUNC_LOCK, omfh_pkg::PID_W'(k * 2000 + 1),
				omfh_pkg::CS_RUNNABLE, omfh_pkg::HS_BLOCKED, 1'b0);
		plan(omfh_pkg::FUNC_LOCK, 16'sd100, omfh_pkg::CS_RUNNABLE, omfh_pkg::HS_BLOCKED, 1'b0);
		// handoff to the head waiter, then heads that are not blocked, then an id below zero
		plan(omfh_pkg::FUNC_UNLOCK, 16'sh7fff, omfh_pkg::CS_RUNNABLE,
			omfh_pkg::HS_BLOCKED, 1'b0);
		plan(omfh_pkg::FUNC_UNLOCK, 16'sd1, omfh_pkg::CS_RUNNABLE,
			omfh_pkg::HS_NOT_FOUND, 1'b1);
		plan(omfh_pkg::FUNC_UNLOCK, 16'sd1, omfh_pkg::CS_RUNNABLE, omfh_pkg::HS_OTHER, 1'b1);
		plan(omfh_pkg::FUNC_UNLOCK, -16'sd1, omfh_pkg::CS_RUNNABLE,
			omfh_pkg::HS_BLOCKED, 1'b0);
		drain();

		// random segments; config changes only between them, with the block idle
		n_planned = 0;
		while (n_planned < ITEMS) begin
			ready_sel = ($urandom_range(0, 7) != 0);
			seg_len = ready_sel ? $urandom_range(60, 220) : $urandom_range(10, 25);
			lock_pct = $urandom_range(25, 80);
			calm = (n_planned >= ITEMS - CALM_TAIL);
			idle_on = ($urandom_range(0, 3) != 0);
			set_kernel_ready(ready_sel);
			for (int k = 0; k < seg_len; k++)
				plan_random(lock_pct);
			n_planned += seg_len;
			drain();
		end
		// leave the kernel up at the end
		set_kernel_ready(1'b1);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests, %0d results in %0d cycles: %0d granted or handed off",
			n_requests, n_results, cycles, status_hits[omfh_pkg::ST_OK]);
		$display("%0d queued, %0d handoffs, %0d full, %0d state, %0d range, %0d not found",
			status_hits[omfh_pkg::ST_BLOCKED], n_handoffs,
			status_hits[omfh_pkg::ST_FULL], status_hits[omfh_pkg::ST_STATE],
			status_hits[omfh_pkg::ST_RANGE], status_hits[omfh_pkg::ST_NOT_FOUND]);
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("** owned_mutex_fifo_handoff: PASSED **");
		else
			$display("** owned_mutex_fifo_handoff: FAILED **");
		$finish;
	end

endmodule
